// ===== hdl/fpa_pkg.sv =====
// Shared types and constants for the signed fixed-point ALU.
// Depends on nothing; every other file of the block imports it.
package fpa_pkg;

  // Number of fraction bits in a raw word.
  localparam int unsigned FRAC_BITS = 8;
  // Quotient bits of the divider: the magnitude of a shifted left by FRAC_BITS.
  localparam int unsigned NQ = 32 + FRAC_BITS;
  // Width of an unsigned magnitude from either the multiplier or the divider.
  localparam int unsigned MAG_W = ((64 - FRAC_BITS) > (NQ + 1)) ? (64 - FRAC_BITS) : (NQ + 1);

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_INC      = 4'd4,
    CMD_DEC      = 4'd5,
    CMD_MIN      = 4'd6,
    CMD_MAX      = 4'd7,
    CMD_TO_INT   = 4'd8,
    CMD_FROM_INT = 4'd9
  } cmd_e;

  // Per-word information that travels down the pipeline.
  typedef struct packed {
    cmd_e             cmd;
    logic             gt;
    logic             lt;
    logic             eq;
    logic             neg;
    logic             ovf;
    logic             dz;
    logic [31:0]      res;
    logic [MAG_W-1:0] mag;
  } info_t;

  // State of the restoring divider.
  typedef struct packed {
    logic [31:0]   rem;
    logic [NQ-1:0] nq;
    logic [31:0]   d;
  } div_t;

  // One finished result word.
  typedef struct packed {
    logic [31:0] res;
    logic        gt;
    logic        lt;
    logic        eq;
    logic        ovf;
    logic        dz;
  } res_t;

endpackage

// ===== hdl/fixed_point_q24_8_alu.sv =====
// Top level of the pipelined signed fixed-point ALU.
// Depends on fpa_pkg, fpa_front, fpa_mul, fpa_div_step, fpa_back and fpa_skid.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o) takes one word per cycle unless
//   stalled: an opcode and two raw 32-bit operands with FRAC_BITS fraction bits.
//   The output channel (out_valid_o / out_ready_i) returns one result word per
//   input word, in order: the raw result, the three comparison flags of the
//   operands, and the overflow and divide-by-zero flags.
//   Every word runs through the same pipeline: a front stage, two multiplier
//   stages, one restoring divider stage per quotient bit (32 + FRAC_BITS of
//   them), two back stages and the output register, for every operation. The
//   throughput is one word per cycle while the receiver does not stall; the
//   divider chain sets the depth and the multiplier stage the longest path.
//   When the receiver stalls, the pipeline keeps moving until one finished
//   word waits in the output register and one in the skid entry; then the
//   whole pipeline holds and in_ready_o drops. Nothing is lost or repeated.
//   Reset clears all valid bits; the data registers are not reset.
module fixed_point_q24_8_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  cmd_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_o,
  output logic        a_greater_o,
  output logic        a_less_o,
  output logic        a_equal_o,
  output logic        overflow_o,
  output logic        div_by_zero_o
);
  import fpa_pkg::*;

  // The whole pipeline advances together whenever the skid entry is free.
  logic        en;
  logic        f_valid;
  info_t       f_info;
  div_t        f_div;
  logic [31:0] f_amag;

  // Divider chain: index 0 is the multiplier output, index NQ the last step.
  logic        d_valid [NQ+1];
  info_t       d_info  [NQ+1];
  div_t        d_div   [NQ+1];

  logic        b_valid;
  res_t        b_res;
  res_t        o_res;

  fpa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .cmd_i   (cmd_i),
    .a_i     (operand_a_i),
    .b_i     (operand_b_i),
    .valid_o (f_valid),
    .info_o  (f_info),
    .div_o   (f_div),
    .amag_o  (f_amag)
  );

  fpa_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .info_i  (f_info),
    .div_i   (f_div),
    .amag_i  (f_amag),
    .valid_o (d_valid[0]),
    .info_o  (d_info[0]),
    .div_o   (d_div[0])
  );

  for (genvar i = 0; i < NQ; i++) begin : g_div
    fpa_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (d_valid[i]),
      .info_i  (d_info[i]),
      .div_i   (d_div[i]),
      .valid_o (d_valid[i+1]),
      .info_o  (d_info[i+1]),
      .div_o   (d_div[i+1])
    );
  end

  fpa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid[NQ]),
    .info_i  (d_info[NQ]),
    .div_i   (d_div[NQ]),
    .valid_o (b_valid),
    .res_o   (b_res)
  );

  fpa_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .up_valid_i  (b_valid),
    .up_data_i   (b_res),
    .up_ready_o  (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (o_res)
  );

  assign in_ready_o    = en;
  assign result_o      = o_res.res;
  assign a_greater_o   = o_res.gt;
  assign a_less_o      = o_res.lt;
  assign a_equal_o     = o_res.eq;
  assign overflow_o    = o_res.ovf;
  assign div_by_zero_o = o_res.dz;
endmodule

// ===== hdl/fpa_front.sv =====
// First pipeline stage: decode, compare, simple operations and operand magnitudes.
// Depends on fpa_pkg.
module fpa_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [3:0]           cmd_i,
  input  logic [31:0]          a_i,
  input  logic [31:0]          b_i,
  output logic                 valid_o,
  output fpa_pkg::info_t       info_o,
  output fpa_pkg::div_t        div_o,
  output logic [31:0]          amag_o
);
  import fpa_pkg::*;

  logic        valid_q;
  info_t       info_d, info_q;
  div_t        div_d, div_q;
  logic [31:0] amag, bmag, tmag;
  logic [32:0] s_add, s_sub, s_inc, s_dec;
  logic [FRAC_BITS:0] hi;
  cmd_e        cmd;

  always_comb begin
    cmd   = cmd_e'(cmd_i);
    amag  = a_i[31] ? (~a_i + 32'd1) : a_i;
    bmag  = b_i[31] ? (~b_i + 32'd1) : b_i;
    tmag  = amag >> FRAC_BITS;
    s_add = {a_i[31], a_i} + {b_i[31], b_i};
    s_sub = {a_i[31], a_i} - {b_i[31], b_i};
    s_inc = {a_i[31], a_i} + 33'd1;
    s_dec = {a_i[31], a_i} - 33'd1;
    hi    = a_i[31:31-FRAC_BITS];

    info_d      = '0;
    info_d.cmd  = cmd;
    info_d.gt   = $signed(a_i) > $signed(b_i);
    info_d.lt   = $signed(a_i) < $signed(b_i);
    info_d.eq   = a_i == b_i;
    info_d.neg  = a_i[31] ^ b_i[31];
    case (cmd)
      CMD_ADD: begin
        info_d.res = s_add[31:0];
        info_d.ovf = s_add[32] ^ s_add[31];
      end
      CMD_SUB: begin
        info_d.res = s_sub[31:0];
        info_d.ovf = s_sub[32] ^ s_sub[31];
      end
      CMD_DIV: begin
        info_d.dz = b_i == 32'd0;
      end
      CMD_INC: begin
        info_d.res = s_inc[31:0];
        info_d.ovf = s_inc[32] ^ s_inc[31];
      end
      CMD_DEC: begin
        info_d.res = s_dec[31:0];
        info_d.ovf = s_dec[32] ^ s_dec[31];
      end
      CMD_MIN: begin
        info_d.res = info_d.lt ? a_i : b_i;
      end
      CMD_MAX: begin
        info_d.res = info_d.gt ? a_i : b_i;
      end
      CMD_TO_INT: begin
        info_d.res = a_i[31] ? (~tmag + 32'd1) : tmag;
      end
      CMD_FROM_INT: begin
        info_d.res = a_i << FRAC_BITS;
        info_d.ovf = (|hi) && !(&hi);
      end
      default: begin
        info_d.res = '0;
      end
    endcase

    div_d.rem = '0;
    div_d.nq  = {amag, {FRAC_BITS{1'b0}}};
    div_d.d   = bmag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      info_q <= info_d;
      div_q  <= div_d;
      amag_o <= amag;
    end
  end

  assign valid_o = valid_q;
  assign info_o  = info_q;
  assign div_o   = div_q;
endmodule

// ===== hdl/fpa_mul.sv =====
// Two multiplier stages: magnitude product, then round to nearest and drop fraction bits.
// Depends on fpa_pkg.
module fpa_mul (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  fpa_pkg::info_t info_i,
  input  fpa_pkg::div_t  div_i,
  input  logic [31:0]    amag_i,
  output logic           valid_o,
  output fpa_pkg::info_t info_o,
  output fpa_pkg::div_t  div_o
);
  import fpa_pkg::*;

  localparam logic [63:0] Half = 64'd1 << (FRAC_BITS - 1);

  logic        v1_q, v2_q;
  info_t       info1_q, info2_q, info2_d;
  div_t        div1_q, div2_q;
  logic [63:0] prod_q, rnd;

  always_comb begin
    rnd     = (prod_q + Half) >> FRAC_BITS;
    info2_d = info1_q;
    if (info1_q.cmd == CMD_MUL) begin
      info2_d.mag = rnd[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= 64'(amag_i) * 64'(div_i.d);
      info1_q <= info_i;
      div1_q  <= div_i;
      info2_q <= info2_d;
      div2_q  <= div1_q;
    end
  end

  assign valid_o = v2_q;
  assign info_o  = info2_q;
  assign div_o   = div2_q;
endmodule

// ===== hdl/fpa_div_step.sv =====
// One registered step of the restoring divider: one quotient bit per stage.
// Depends on fpa_pkg.
module fpa_div_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  fpa_pkg::info_t info_i,
  input  fpa_pkg::div_t  div_i,
  output logic           valid_o,
  output fpa_pkg::info_t info_o,
  output fpa_pkg::div_t  div_o
);
  import fpa_pkg::*;

  logic        valid_q;
  info_t       info_q;
  div_t        div_d, div_q;
  logic [32:0] t, diff;
  logic        ge;

  always_comb begin
    t         = {div_i.rem, div_i.nq[NQ-1]};
    diff      = t - {1'b0, div_i.d};
    ge        = t >= {1'b0, div_i.d};
    div_d.rem = ge ? diff[31:0] : t[31:0];
    div_d.nq  = {div_i.nq[NQ-2:0], ge};
    div_d.d   = div_i.d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      info_q <= info_i;
      div_q  <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign info_o  = info_q;
  assign div_o   = div_q;
endmodule

// ===== hdl/fpa_back.sv =====
// Last two stages: quotient rounding, then sign, overflow check and result select.
// Depends on fpa_pkg.
module fpa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  fpa_pkg::info_t info_i,
  input  fpa_pkg::div_t  div_i,
  output logic           valid_o,
  output fpa_pkg::res_t  res_o
);
  import fpa_pkg::*;

  logic        v3_q, v4_q;
  info_t       info3_d, info3_q;
  res_t        res_d, res_q;
  logic        rup, ov;
  logic [31:0] lo;

  always_comb begin
    rup     = {div_i.rem, 1'b0} >= {1'b0, div_i.d};
    info3_d = info_i;
    if (info_i.cmd == CMD_DIV) begin
      info3_d.mag = MAG_W'(div_i.nq) + MAG_W'(rup);
    end
  end

  always_comb begin
    lo        = info3_q.mag[31:0];
    ov        = (|info3_q.mag[MAG_W-1:32]) ||
                (info3_q.mag[31] && (!info3_q.neg || (|info3_q.mag[30:0])));
    res_d.gt  = info3_q.gt;
    res_d.lt  = info3_q.lt;
    res_d.eq  = info3_q.eq;
    res_d.dz  = info3_q.dz;
    if (info3_q.dz) begin
      res_d.res = '0;
      res_d.ovf = 1'b0;
    end else if (info3_q.cmd == CMD_MUL || info3_q.cmd == CMD_DIV) begin
      res_d.res = info3_q.neg ? (~lo + 32'd1) : lo;
      res_d.ovf = ov;
    end else begin
      res_d.res = info3_q.res;
      res_d.ovf = info3_q.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      info3_q <= info3_d;
      res_q   <= res_d;
    end
  end

  assign valid_o = v4_q;
  assign res_o   = res_q;
endmodule

// ===== hdl/fpa_skid.sv =====
// Output register with a skid entry that decouples the pipeline from receiver stalls.
// Depends on fpa_pkg.
module fpa_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          up_valid_i,
  input  fpa_pkg::res_t up_data_i,
  output logic          up_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fpa_pkg::res_t out_data_o
);
  import fpa_pkg::*;

  logic out_valid_q, out_valid_d, skid_valid_q, skid_valid_d, take;
  res_t out_q, out_d, skid_q, skid_d;

  always_comb begin
    take         = up_valid_i && !skid_valid_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_ready_i) begin
      out_valid_d  = skid_valid_q || take;
      out_d        = skid_valid_q ? skid_q : up_data_i;
      skid_valid_d = 1'b0;
    end else if (take) begin
      skid_valid_d = 1'b1;
      skid_d       = up_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign up_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the pipelined signed Q24.8 fixed-point ALU.
// Depends on fpa_pkg and fixed_point_q24_8_alu; predicts each result word itself.
`timescale 1ns / 1ps

module tb;
  import fpa_pkg::*;

  localparam int unsigned LATENCY = 38 + FRAC_BITS;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] a;
    logic [31:0] b;
  } op_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [3:0]  cmd_i;
  logic [31:0] operand_a_i;
  logic [31:0] operand_b_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] result_o;
  logic        a_greater_o;
  logic        a_less_o;
  logic        a_equal_o;
  logic        overflow_o;
  logic        div_by_zero_o;

  op_word_t pending_ops[$];
  res_t     expected_results[$];
  int       error_count;
  int       cycle_count;
  bit       idle_off;     // Set in the last part of the run: no more gaps.
  bit       hold_sender;  // Sender holds off until the pipeline has drained.
  bit       in_taken;     // The presented word was accepted at the last rising edge.
  int       send_gap;
  int       recv_gap;

  fixed_point_q24_8_alu DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .operand_a_i  (operand_a_i),
    .operand_b_i  (operand_b_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result_o),
    .a_greater_o  (a_greater_o),
    .a_less_o     (a_less_o),
    .a_equal_o    (a_equal_o),
    .overflow_o   (overflow_o),
    .div_by_zero_o(div_by_zero_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Wrap an exact value to 32 bits and flag it when it did not fit.
  function automatic logic [31:0] wrap32(input logic signed [65:0] v, output logic ovf);
    ovf = (v < -66'sd2147483648) || (v > 66'sd2147483647);
    return v[31:0];
  endfunction

  // Predicts the result word of the ALU for one operation word. All
  // arithmetic is done exactly at 66 bits so nothing overflows on the way.
  function automatic res_t alu_predict(input op_word_t w);
    res_t r;
    logic signed [65:0] a, b, p, m;
    logic [65:0] mag_a, mag_b, num, q;
    logic neg;
    a = {{34{w.a[31]}}, w.a};
    b = {{34{w.b[31]}}, w.b};
    r = '0;
    r.gt = a > b;
    r.lt = a < b;
    r.eq = a == b;
    mag_a = a < 0 ? -a : a;
    mag_b = b < 0 ? -b : b;
    case (w.cmd)
      CMD_ADD: r.res = wrap32(a + b, r.ovf);
      CMD_SUB: r.res = wrap32(a - b, r.ovf);
      CMD_INC: r.res = wrap32(a + 1, r.ovf);
      CMD_DEC: r.res = wrap32(a - 1, r.ovf);
      CMD_MUL: begin
        p = a * b;
        neg = p < 0;
        // Round half away from zero on the magnitude.
        m = ((neg ? -p : p) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        r.res = wrap32(neg ? -m : m, r.ovf);
      end
      CMD_DIV: begin
        if (w.b == '0) begin
          r.dz = 1'b1;
        end else begin
          neg = (a < 0) != (b < 0);
          num = mag_a << FRAC_BITS;
          q = (2 * num + mag_b) / (2 * mag_b);
          m = q;
          r.res = wrap32(neg ? -m : m, r.ovf);
        end
      end
      CMD_MIN: r.res = (a < b) ? w.a : w.b;
      CMD_MAX: r.res = (a > b) ? w.a : w.b;
      CMD_TO_INT: begin
        // Truncation toward zero: shift the magnitude, then restore the sign.
        m = mag_a >> FRAC_BITS;
        r.res = wrap32(a < 0 ? -m : m, r.ovf);
      end
      CMD_FROM_INT: r.res = wrap32(a <<< FRAC_BITS, r.ovf);
      default: r.res = '0;  // Unused codes give zero and no overflow or divide-by-zero flag.
    endcase
    return r;
  endfunction

  // Operands biased toward the edges of the range, zero and small values.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 2) - 1;
      3: return {{20{$urandom_range(0, 1) == 1}}, 12'($urandom)};
      4: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(input logic [3:0] c, input logic [31:0] a, input logic [31:0] b);
    op_word_t w;
    w.cmd = c;
    w.a = a;
    w.b = b;
    pending_ops.push_back(w);
  endtask

  // Driver: presents the oldest pending word at the falling edge and holds it
  // until it is accepted. Random idle bursts fall between words, and the receiver stalls at random.
  always @(negedge clk_i) begin
    bit taken;
    if (rst_ni) begin
      taken = in_taken;
      in_taken = 1'b0;
      if (taken && !idle_off && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 14);
      if (in_valid_i && !taken) begin
        in_valid_i <= 1'b1;
      end else if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap = send_gap - 1;
      end else if (pending_ops.size() > 0 && !hold_sender) begin
        in_valid_i  <= 1'b1;
        cmd_i       <= pending_ops[0].cmd;
        operand_a_i <= pending_ops[0].a;
        operand_b_i <= pending_ops[0].b;
      end else begin
        in_valid_i <= 1'b0;
      end
      if (recv_gap > 0) begin
        out_ready_i <= 1'b0;
        recv_gap = recv_gap - 1;
      end else if (!idle_off && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        recv_gap = $urandom_range(0, 13);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Input monitor: each accepted word gets its expected result queued and
  // leaves the pending queue.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_results.push_back(alu_predict(op_word_t'{cmd_i, operand_a_i, operand_b_i}));
      void'(pending_ops.pop_front());
      in_taken = 1'b1;
    end
  end

  // Output monitor: compares each accepted result word with the oldest one.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result word with none expected: res=%h", $time, result_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (want.res !== result_o || want.gt !== a_greater_o || want.lt !== a_less_o ||
            want.eq !== a_equal_o || want.ovf !== overflow_o || want.dz !== div_by_zero_o) begin
          $display("%0t: mismatch expected res=%h gt=%b lt=%b eq=%b ovf=%b dz=%b", $time,
                   want.res, want.gt, want.lt, want.eq, want.ovf, want.dz);
          $display("%0t:            actual res=%h gt=%b lt=%b eq=%b ovf=%b dz=%b", $time,
                   result_o, a_greater_o, a_less_o, a_equal_o, overflow_o, div_by_zero_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** fixed_point_q24_8_alu: FAILED **");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    idle_off = 1'b0;
    hold_sender = 1'b0;
    in_taken = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    cmd_i = '0;
    operand_a_i = '0;
    operand_b_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed words: every operation, the operand extremes, divide by zero,
    // rounding ties both ways, and two unused codes.
    queue_op(CMD_ADD, 32'h7FFFFFFF, 32'h00000001);
    queue_op(CMD_SUB, 32'h80000000, 32'h00000001);
    queue_op(CMD_MUL, 32'h80000000, 32'h80000000);
    queue_op(CMD_MUL, 32'h00000180, 32'h00000001);
    queue_op(CMD_MUL, 32'hFFFFFE80, 32'h00000001);
    queue_op(CMD_MUL, 32'h7FFFFFFF, 32'hFFFFFFFF);
    queue_op(CMD_DIV, 32'h12345678, 32'h00000000);
    queue_op(CMD_DIV, 32'h80000000, 32'h00000001);
    queue_op(CMD_DIV, 32'h80000000, 32'hFFFFFFFF);
    queue_op(CMD_DIV, 32'h00000001, 32'h00000200);
    queue_op(CMD_DIV, 32'hFFFFFFFF, 32'h00000200);
    queue_op(CMD_INC, 32'h7FFFFFFF, 32'h7FFFFFFF);
    queue_op(CMD_DEC, 32'h80000000, 32'h80000000);
    queue_op(CMD_MIN, 32'h80000000, 32'h7FFFFFFF);
    queue_op(CMD_MAX, 32'h80000000, 32'h7FFFFFFF);
    queue_op(CMD_TO_INT, 32'hFFFFFF01, 32'h0);
    queue_op(CMD_TO_INT, 32'h80000000, 32'h0);
    queue_op(CMD_FROM_INT, 32'h00800000, 32'h0);
    queue_op(CMD_FROM_INT, 32'hFF800000, 32'h0);
    queue_op(4'd10, 32'hFFFFFFFF, 32'h0);
    queue_op(4'd15, 32'h0, 32'hFFFFFFFF);
    wait (pending_ops.size() == 0);

    // Hold the sender until the pipeline has drained completely.
    hold_sender = 1'b1;
    wait (expected_results.size() == 0);
    hold_sender = 1'b0;

    for (int i = 0; i < 1900; i++) begin
      logic [31:0] a;
      a = pick_operand();
      queue_op($urandom_range(0, 19) == 0 ? 4'($urandom_range(10, 15))
                                           : 4'($urandom_range(0, 9)),
               a, $urandom_range(0, 15) == 0 ? a : pick_operand());
      if (i == 1600) idle_off = 1'b1;
      if (pending_ops.size() > 64) wait (pending_ops.size() < 16);
    end
    wait (pending_ops.size() == 0);
    wait (expected_results.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);

    if (error_count == 0) begin
      $display("** fixed_point_q24_8_alu: PASSED **");
    end else begin
      $display("** fixed_point_q24_8_alu: FAILED **");
    end
    $finish;
  end

endmodule
